>>> rtl/kpsc_pkg.sv
package kpsc_pkg;

  // Grid geometry.
  localparam int GridSide = 6;
  localparam int Cells    = GridSide * GridSide;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_KEY     = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Character constants.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_EMIT_A,
    ST_EMIT_B
  } kpsc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic fill_step;  // place the next symbol of the grid completion walk
    logic read;       // launch the grid and position lookups
    logic emit_a;     // resolve the first result of a text item
    logic emit_b;     // load the second (column) result of an encrypted symbol
  } kpsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_text;
    logic grid_complete;
    logic fill_last;
    logic no_result;
    logic two_results;
    logic out_free;
  } kpsc_stat_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] code;
  } kpsc_sym_t;

  // Symbol code: 0-25 for 'A'-'Z', 26-35 for '0'-'9'.
  function automatic kpsc_sym_t sym_code(input logic [7:0] c);
    kpsc_sym_t s;
    s.valid = 1'b0;
    s.code  = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.valid = 1'b1;
      s.code  = 6'(c - CHAR_A);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.valid = 1'b1;
      s.code  = 6'(c - CHAR_ZERO) + 6'd26;
    end
    return s;
  endfunction

  function automatic logic [7:0] sym_char(input logic [5:0] code);
    logic [7:0] c;
    if (code < 6'd26) begin
      c = CHAR_A + {2'b00, code};
    end else if (code < 6'(Cells)) begin
      c = CHAR_ZERO + {2'b00, code - 6'd26};
    end else begin
      c = CHAR_SPACE;
    end
    return c;
  endfunction

  // Row of a cell index, by comparison against the row starts.
  function automatic logic [2:0] pos_row(input logic [5:0] pos);
    logic [2:0] r;
    r = '0;
    for (int i = 1; i < GridSide; i++) begin
      if (pos >= 6'(i * GridSide)) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Row times the grid side, built from shifts (side is six).
  function automatic logic [5:0] row_base(input logic [2:0] r);
    return 6'({r, 2'b00}) + 6'({r, 1'b0});
  endfunction

  function automatic logic [2:0] pos_col(input logic [5:0] pos);
    return 3'(pos - row_base(pos_row(pos)));
  endfunction

endpackage

>>> rtl/kpsc_item_if.sv
interface kpsc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] in_char;

  modport source (output valid, output operation, output in_char, input ready);
  modport sink (input valid, input operation, input in_char, output ready);
endinterface

>>> rtl/kpsc_res_if.sv
interface kpsc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       error;

  modport source (output valid, output out_char, output last, output error, input ready);
  modport sink (input valid, input out_char, input last, input error, output ready);
endinterface

>>> rtl/kpsc_cfg_if.sv
interface kpsc_cfg_if;
  logic valid;
  logic ready;
  logic encrypt_mode;

  modport source (output valid, output encrypt_mode, input ready);
  modport sink (input valid, input encrypt_mode, output ready);
endinterface

>>> rtl/keyed_polybius_square_cipher.sv
// Keyed 6x6 Polybius square over A-Z then 0-9. Key items (operation 0) load
// uppercase letters and digits into the grid in arrival order; repeats and other
// characters are dropped, and each key item is absorbed in its transaction with
// no result. A restart item (operation 2) clears the key and any pending decrypt
// digit, also with no result. The first text item (operation 1) after loading
// first completes the grid with the unused symbols in alphabet order, a walk that
// happens once per key. In encrypt mode a letter or digit yields two result
// transactions, the row digit and then the column digit; any other character
// yields one space, with error set for a lowercase letter. In decrypt mode a row
// digit '0'-'5' is held without a result, the column digit then yields the grid
// symbol, a space passes through (with error set if it breaks a digit pair), and
// anything else gives a space with error set. The block works on one item at a
// time: a key or restart item is taken in its transaction, a text item holds the
// block through the accept, the lookup into the grid memories and the result
// register load, an encrypted symbol adds a second load for the column digit, and
// the first text item after a key change adds the completion walk before the
// lookup. A result load waits while the result register still holds a result
// that the consumer has not taken. The result register decouples the output, so a
// finished result can wait on a stalled consumer while the next item is taken.
// The mode register is written through the configuration channel, which is
// always ready, and should be changed only while no item is in flight.
module keyed_polybius_square_cipher (
  input logic        clk_i,
  input logic        rst_ni,
  kpsc_item_if.sink  item_i,
  kpsc_res_if.source result_o,
  kpsc_cfg_if.sink   cfg_i
);

  kpsc_pkg::kpsc_cmd_t  cmd;
  kpsc_pkg::kpsc_stat_t stat;

  // The mode register takes every write; there is nothing to wait on.
  assign cfg_i.ready = 1'b1;

  // The controller sequences accept, completion walk, lookup and result loads.
  kpsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the grid memories, key state and the result register.
  kpsc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (item_i.operation),
    .in_char_i   (item_i.in_char),
    .cfg_valid_i (cfg_i.valid),
    .cfg_mode_i  (cfg_i.encrypt_mode),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_char_o  (result_o.out_char),
    .out_last_o  (result_o.last),
    .out_error_o (result_o.error)
  );

endmodule

>>> rtl/kpsc_datapath.sv
module kpsc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kpsc_pkg::kpsc_cmd_t cmd_i,
  output kpsc_pkg::kpsc_stat_t stat_o,
  input  logic [1:0]          in_op_i,
  input  logic [7:0]          in_char_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_mode_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_char_o,
  output logic                out_last_o,
  output logic                out_error_o
);

  // Grid contents and the inverse map; both are fully written before any lookup.
  logic [5:0] grid_mem [kpsc_pkg::Cells];
  logic [5:0] pos_mem  [kpsc_pkg::Cells];

  logic [kpsc_pkg::Cells-1:0] used_q;
  logic [5:0] filled_q;
  logic       complete_q;
  logic       mode_q;
  logic       pend_valid_q;
  logic [2:0] pend_row_q;
  logic [5:0] fill_k_q;
  logic [7:0] char_q;
  logic [5:0] pos_rd_q;
  logic [5:0] grid_rd_q;
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic       out_error_q;

  kpsc_pkg::kpsc_sym_t key_sym;
  kpsc_pkg::kpsc_sym_t item_sym;
  logic       place_try;
  logic       place_en;
  logic [5:0] place_code;
  logic       is_dig6;
  logic [2:0] digit;
  logic [5:0] grid_addr;
  logic       is_lower;
  logic       no_result;
  logic       load_out;
  logic [7:0] res_char;
  logic       res_last;
  logic       res_error;

  assign key_sym  = kpsc_pkg::sym_code(in_char_i);
  assign item_sym = kpsc_pkg::sym_code(char_q);
  assign is_dig6  = (char_q >= kpsc_pkg::CHAR_ZERO) && (char_q < 8'h36);
  assign digit    = char_q[2:0];
  assign grid_addr = kpsc_pkg::row_base(pend_row_q) + {3'b000, digit};
  assign is_lower = (char_q >= 8'h61) && (char_q <= 8'h7A);
  assign no_result = !mode_q && is_dig6 && !pend_valid_q;

  // A symbol is placed by a key character or by one step of the completion walk.
  always_comb begin
    place_try  = 1'b0;
    place_code = fill_k_q;
    if (cmd_i.accept && (in_op_i == kpsc_pkg::OP_KEY) && !complete_q && key_sym.valid) begin
      place_try  = 1'b1;
      place_code = key_sym.code;
    end else if (cmd_i.fill_step) begin
      place_try  = 1'b1;
    end
    place_en = place_try && !used_q[place_code] && (filled_q < 6'(kpsc_pkg::Cells));
  end

  // First or second result of the current text item.
  always_comb begin
    res_char  = kpsc_pkg::CHAR_SPACE;
    res_last  = 1'b1;
    res_error = 1'b0;
    if (cmd_i.emit_b) begin
      res_char = kpsc_pkg::CHAR_ZERO + {5'b00000, kpsc_pkg::pos_col(pos_rd_q)};
    end else if (mode_q) begin
      if (item_sym.valid) begin
        res_char = kpsc_pkg::CHAR_ZERO + {5'b00000, kpsc_pkg::pos_row(pos_rd_q)};
        res_last = 1'b0;
      end else begin
        res_error = is_lower;
      end
    end else if (is_dig6) begin
      res_char = kpsc_pkg::sym_char(grid_rd_q);
    end else if (char_q == kpsc_pkg::CHAR_SPACE) begin
      res_error = pend_valid_q;
    end else begin
      res_error = 1'b1;
    end
  end

  assign load_out = (cmd_i.emit_a && !no_result) || cmd_i.emit_b;

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      grid_mem[filled_q] <= place_code;
      pos_mem[place_code] <= filled_q;
    end
    if (cmd_i.read) begin
      if (item_sym.valid) begin
        pos_rd_q <= pos_mem[item_sym.code];
      end
      if (is_dig6) begin
        grid_rd_q <= grid_mem[grid_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= in_char_i;
    end
    if (load_out) begin
      out_char_q  <= res_char;
      out_last_q  <= res_last;
      out_error_q <= res_error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      filled_q     <= '0;
      complete_q   <= 1'b0;
      mode_q       <= 1'b1;
      pend_valid_q <= 1'b0;
      pend_row_q   <= '0;
      fill_k_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_mode_i;
      end
      if (cmd_i.accept) begin
        fill_k_q <= '0;
      end else if (cmd_i.fill_step) begin
        fill_k_q <= fill_k_q + 6'd1;
        if (fill_k_q == 6'(kpsc_pkg::Cells - 1)) begin
          complete_q <= 1'b1;
        end
      end
      if (place_en) begin
        used_q[place_code] <= 1'b1;
        filled_q           <= filled_q + 6'd1;
      end
      if (cmd_i.accept && (in_op_i == kpsc_pkg::OP_RESTART)) begin
        used_q       <= '0;
        filled_q     <= '0;
        complete_q   <= 1'b0;
        pend_valid_q <= 1'b0;
        pend_row_q   <= '0;
      end
      if (cmd_i.emit_a && !mode_q) begin
        if (no_result) begin
          pend_valid_q <= 1'b1;
          pend_row_q   <= digit;
        end else begin
          pend_valid_q <= 1'b0;
          pend_row_q   <= '0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.in_is_text    = (in_op_i == kpsc_pkg::OP_TEXT);
  assign stat_o.grid_complete = complete_q;
  assign stat_o.fill_last     = (fill_k_q == 6'(kpsc_pkg::Cells - 1));
  assign stat_o.no_result     = no_result;
  assign stat_o.two_results   = mode_q && item_sym.valid;
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_error_o = out_error_q;

  a_filled_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= 6'(kpsc_pkg::Cells))
    else $error("fill count beyond the grid size");

  a_complete_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> (filled_q == 6'(kpsc_pkg::Cells)))
    else $error("grid marked complete with empty cells");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_valid_q) |-> out_ready_i)
    else $error("result register overwritten before its transaction");

  a_pend_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_row_q < 3'(kpsc_pkg::GridSide)))
    else $error("pending row outside the grid");

endmodule

>>> rtl/kpsc_ctrl.sv
module kpsc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kpsc_pkg::kpsc_stat_t stat_i,
  output kpsc_pkg::kpsc_cmd_t  cmd_o
);

  kpsc_pkg::kpsc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      kpsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.in_is_text) begin
            state_d = stat_i.grid_complete ? kpsc_pkg::ST_READ : kpsc_pkg::ST_FILL;
          end
        end
      end
      kpsc_pkg::ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          state_d = kpsc_pkg::ST_READ;
        end
      end
      kpsc_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = kpsc_pkg::ST_EMIT_A;
      end
      kpsc_pkg::ST_EMIT_A: begin
        if (stat_i.no_result) begin
          cmd_o.emit_a = 1'b1;
          state_d      = kpsc_pkg::ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit_a = 1'b1;
          state_d      = stat_i.two_results ? kpsc_pkg::ST_EMIT_B : kpsc_pkg::ST_IDLE;
        end
      end
      kpsc_pkg::ST_EMIT_B: begin
        if (stat_i.out_free) begin
          cmd_o.emit_b = 1'b1;
          state_d      = kpsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kpsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> tb/kpsc_cipher_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and configuration channels of the cipher. It keeps its
// own copy of the keyed square and the decrypt row digit, derives the results each
// accepted item must cause, and compares every result transaction against them.
module kpsc_cipher_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  kpsc_item_if  item_i,
  kpsc_res_if   result_i,
  kpsc_cfg_if   cfg_i,
  output int    mismatch_count_o,
  output int    pending_count_o,
  output int    result_count_o
);

  localparam int MaxReports = 10;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       error;
  } cipher_result_t;

  cipher_result_t expected_results[$];

  logic [5:0] square_cell[kpsc_pkg::Cells];    // symbol held in each cell, row-major
  logic [5:0] symbol_cell[kpsc_pkg::Cells];    // cell holding each symbol
  logic       symbol_placed[kpsc_pkg::Cells];
  int         placed_total;
  logic       square_done;
  logic [2:0] held_row;
  logic       row_held;
  logic       encrypting;

  int mismatches;
  int pending;
  int results_seen;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;
  assign result_count_o   = results_seen;

  // Symbol index: 0-25 for 'A'-'Z', 26-35 for '0'-'9', -1 for anything else.
  function automatic int symbol_of(input logic [7:0] c);
    if (c >= kpsc_pkg::CHAR_A && c <= 8'h5A) begin
      return int'(c - kpsc_pkg::CHAR_A);
    end
    if (c >= kpsc_pkg::CHAR_ZERO && c <= 8'h39) begin
      return int'(c - kpsc_pkg::CHAR_ZERO) + 26;
    end
    return -1;
  endfunction

  function automatic logic [7:0] glyph_of(input logic [5:0] code);
    if (code < 6'd26) begin
      return kpsc_pkg::CHAR_A + 8'(code);
    end
    return kpsc_pkg::CHAR_ZERO + 8'(code - 6'd26);
  endfunction

  task automatic expect_result(input logic [7:0] c, input logic is_last, input logic err);
    cipher_result_t r;
    r.out_char = c;
    r.last     = is_last;
    r.error    = err;
    expected_results.push_back(r);
  endtask

  task automatic place_symbol(input int code);
    if (symbol_placed[code] || placed_total >= kpsc_pkg::Cells) begin
      return;
    end
    square_cell[placed_total] = 6'(code);
    symbol_cell[code]         = 6'(placed_total);
    symbol_placed[code]       = 1'b1;
    placed_total++;
  endtask

  task automatic clear_key();
    for (int k = 0; k < kpsc_pkg::Cells; k++) begin
      symbol_placed[k] = 1'b0;
    end
    placed_total = 0;
    square_done  = 1'b0;
    held_row     = '0;
    row_held     = 1'b0;
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [7:0] ch);
    int code;
    int pos;
    int digit;
    code = symbol_of(ch);
    case (op)
      kpsc_pkg::OP_KEY: begin
        if (!square_done && code >= 0) begin
          place_symbol(code);
        end
      end
      kpsc_pkg::OP_RESTART: begin
        clear_key();
      end
      kpsc_pkg::OP_TEXT: begin
        // The first text item after a key change fills the rest in alphabet order.
        if (!square_done) begin
          for (int k = 0; k < kpsc_pkg::Cells; k++) begin
            place_symbol(k);
          end
          square_done = 1'b1;
        end
        if (encrypting) begin
          if (code >= 0) begin
            pos = int'(symbol_cell[code]);
            expect_result(kpsc_pkg::CHAR_ZERO + 8'(pos / kpsc_pkg::GridSide), 1'b0, 1'b0);
            expect_result(kpsc_pkg::CHAR_ZERO + 8'(pos % kpsc_pkg::GridSide), 1'b1, 1'b0);
          end else begin
            expect_result(kpsc_pkg::CHAR_SPACE, 1'b1, (ch >= 8'h61 && ch <= 8'h7A));
          end
        end else if (ch >= kpsc_pkg::CHAR_ZERO &&
                     ch < kpsc_pkg::CHAR_ZERO + 8'(kpsc_pkg::GridSide)) begin
          digit = int'(ch - kpsc_pkg::CHAR_ZERO);
          if (!row_held) begin
            held_row = 3'(digit);
            row_held = 1'b1;
          end else begin
            expect_result(
                glyph_of(square_cell[int'(held_row) * kpsc_pkg::GridSide + digit]),
                1'b1, 1'b0);
            held_row = '0;
            row_held = 1'b0;
          end
        end else begin
          // A space is only an error when it breaks a digit pair.
          expect_result(kpsc_pkg::CHAR_SPACE, 1'b1,
                        (ch == kpsc_pkg::CHAR_SPACE) ? row_held : 1'b1);
          held_row = '0;
          row_held = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input cipher_result_t got);
    cipher_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("Unexpected result transaction %0d: char %h last %b error %b",
                 results_seen, got.out_char, got.last, got.error);
      end
      return;
    end
    want = expected_results.pop_front();
    if (got.out_char !== want.out_char || got.last !== want.last ||
        got.error !== want.error) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("Result %0d: expected char %h last %b error %b, got char %h last %b error %b",
                 results_seen, want.out_char, want.last, want.error,
                 got.out_char, got.last, got.error);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      for (int k = 0; k < kpsc_pkg::Cells; k++) begin
        square_cell[k] = '0;
        symbol_cell[k] = '0;
      end
      clear_key();
      encrypting   = 1'b1;
      mismatches   = 0;
      results_seen = 0;
      pending      = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        check_result({result_i.out_char, result_i.last, result_i.error});
      end
      if (cfg_i.valid && cfg_i.ready) begin
        encrypting = cfg_i.encrypt_mode;
      end
      if (item_i.valid && item_i.ready) begin
        predict_item(item_i.operation, item_i.in_char);
      end
      pending = expected_results.size();
    end
  end

endmodule

>>> tb/tb_keyed_polybius_square_cipher.sv
`timescale 1ns / 100ps

// Top of the cipher testbench. This module only produces stimulus and gives the
// verdict; the checker beside the block predicts and compares every result.
module tb_keyed_polybius_square_cipher;

  // The operation field has one code the block does not use; it must be ignored.
  localparam logic [1:0] OpUnused = 2'd3;

  // Number of input transactions after which the random part stops.
  localparam int ItemTarget = 1300;

  // After the last expected result the block can still be busy with an item that
  // causes none, such as a lone row digit that also triggers the grid completion
  // walk. This many idle cycles cover the walk plus the lookup.
  localparam int SettleCycles = 60;

  // Length of the one deliberate long stall on the result side.
  localparam int LongHoldCycles = 300;

  // Watchdog limit, above what a worst case correct run needs (every item with its
  // longest input gap, the completion walk and two results that each wait out the
  // longest consumer stall).
  localparam int CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;

  kpsc_item_if item_bus ();
  kpsc_res_if  result_bus ();
  kpsc_cfg_if  cfg_bus ();

  int mismatch_count;
  int pending_count;
  int result_count;

  int items_sent;
  int mode_writes;
  int cycle_count;

  // The stimulus process raises hold_request once; the result side answers with
  // one long stall and marks it served. Each bit has a single writer.
  logic hold_request;
  logic hold_served;

  // When set, the sender offers items back to back for the whole phase.
  logic steady;

  keyed_polybius_square_cipher u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  kpsc_cipher_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_bus),
    .result_i         (result_bus),
    .cfg_i            (cfg_bus),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .result_count_o   (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly back-to-back items, some short gaps and a few long ones.
  function automatic int pick_gap();
    int pick;
    if (steady) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return 0;
    end
    if (pick < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] random_symbol();
    int code;
    code = $urandom_range(0, 35);
    if (code < 26) begin
      return kpsc_pkg::CHAR_A + 8'(code);
    end
    return kpsc_pkg::CHAR_ZERO + 8'(code - 26);
  endfunction

  function automatic logic [7:0] random_row_digit();
    return kpsc_pkg::CHAR_ZERO + 8'($urandom_range(0, kpsc_pkg::GridSide - 1));
  endfunction

  // Offers one item and returns at the rising edge where its transaction happens.
  // The payload changes only at falling edges; valid stays high when the next item
  // follows without a gap.
  task automatic offer_item(input logic [1:0] op, input logic [7:0] ch);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      item_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_bus.valid     = 1'b1;
    item_bus.operation = op;
    item_bus.in_char   = ch;
    do @(posedge clk_i); while (!item_bus.ready);
    if (op != OpUnused) begin
      items_sent++;
    end
  endtask

  // Stops offering, waits for every expected result, then lets the block finish
  // any item that causes no result. The mode may be written afterwards.
  task automatic settle();
    @(negedge clk_i);
    item_bus.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic encrypt);
    @(negedge clk_i);
    cfg_bus.valid        = 1'b1;
    cfg_bus.encrypt_mode = encrypt;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
    mode_writes++;
  endtask

  // Restart, then a fresh key. Lengths range from empty (plain alphabet order)
  // through short keywords to keys long enough to fill the whole square, after
  // which further key characters have no room and must be dropped.
  task automatic load_random_key();
    int pick;
    int len;
    int j;
    logic [7:0] tmp;
    logic [7:0] order[kpsc_pkg::Cells];
    offer_item(kpsc_pkg::OP_RESTART, 8'($urandom));
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      for (int k = 0; k < kpsc_pkg::Cells; k++) begin
        order[k] = (k < 26) ? kpsc_pkg::CHAR_A + 8'(k) : kpsc_pkg::CHAR_ZERO + 8'(k - 26);
      end
      for (int k = kpsc_pkg::Cells - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (int k = 0; k < kpsc_pkg::Cells; k++) begin
        offer_item(kpsc_pkg::OP_KEY, order[k]);
      end
      len = $urandom_range(1, 4);
    end else if (pick < 2) begin
      len = 0;
    end else if (pick < 7) begin
      len = $urandom_range(1, 12);
    end else begin
      len = $urandom_range(30, 60);
    end
    repeat (len) begin
      if ($urandom_range(0, 9) < 8) begin
        offer_item(kpsc_pkg::OP_KEY, random_symbol());
      end else begin
        offer_item(kpsc_pkg::OP_KEY, 8'($urandom));
      end
    end
  endtask

  // Occasional noise between text items: unused operation codes, late key
  // characters (ignored once the square is complete) and a rare restart.
  task automatic maybe_noise();
    int pick;
    pick = $urandom_range(0, 199);
    if (pick < 4) begin
      offer_item(OpUnused, 8'($urandom));
    end else if (pick < 7) begin
      offer_item(kpsc_pkg::OP_KEY, random_symbol());
    end else if (pick == 7) begin
      offer_item(kpsc_pkg::OP_RESTART, 8'($urandom));
    end
  endtask

  task automatic encrypt_text(input int count);
    int pick;
    logic [7:0] ch;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        ch = random_symbol();
      end else if (pick < 80) begin
        ch = 8'h61 + 8'($urandom_range(0, 25));
      end else if (pick < 85) begin
        ch = kpsc_pkg::CHAR_SPACE;
      end else begin
        ch = 8'($urandom);
      end
      maybe_noise();
      offer_item(kpsc_pkg::OP_TEXT, ch);
    end
  endtask

  // Mostly well-formed digit pairs, with spaces, lone digits that shift the
  // pairing, digits outside the grid and arbitrary bytes mixed in.
  task automatic decrypt_text(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      maybe_noise();
      if (pick < 75) begin
        offer_item(kpsc_pkg::OP_TEXT, random_row_digit());
        offer_item(kpsc_pkg::OP_TEXT, random_row_digit());
      end else if (pick < 82) begin
        offer_item(kpsc_pkg::OP_TEXT, kpsc_pkg::CHAR_SPACE);
      end else if (pick < 88) begin
        offer_item(kpsc_pkg::OP_TEXT, random_row_digit());
      end else if (pick < 94) begin
        offer_item(kpsc_pkg::OP_TEXT, 8'($urandom));
      end else begin
        offer_item(kpsc_pkg::OP_TEXT,
                   kpsc_pkg::CHAR_ZERO + 8'($urandom_range(kpsc_pkg::GridSide, 9)));
      end
    end
  endtask

  // Result side: mostly ready, short and occasional longer stalls, some stretches
  // of continuous readiness, and one long stall on request from the stimulus so
  // that the block backs up and refuses input.
  initial begin : result_sink
    int pick;
    int steady_left;
    result_bus.ready = 1'b0;
    hold_served      = 1'b0;
    steady_left      = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_served) begin
        result_bus.ready = 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
        hold_served = 1'b1;
      end else if (steady_left > 0) begin
        result_bus.ready = 1'b1;
        steady_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          steady_left = $urandom_range(50, 150);
        end
        if (pick < 70) begin
          result_bus.ready = 1'b1;
        end else if (pick < 96) begin
          result_bus.ready = 1'b0;
        end else begin
          result_bus.ready = 1'b0;
          repeat ($urandom_range(8, 40)) @(negedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still outstanding.",
             cycle_count, pending_count);
    $display("** keyed_polybius_square_cipher: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int   phase;
    logic encrypt;
    items_sent           = 0;
    mode_writes          = 0;
    hold_request         = 1'b0;
    steady               = 1'b0;
    item_bus.valid       = 1'b0;
    item_bus.operation   = kpsc_pkg::OP_KEY;
    item_bus.in_char     = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.encrypt_mode = 1'b1;
    rst_ni               = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed encrypt checks. The key "Z9A" with a repeated Z and a non-symbol
    // byte gives a square starting Z, 9, A, then B, C and so on.
    write_mode(1'b1);
    offer_item(kpsc_pkg::OP_KEY, "Z");
    offer_item(kpsc_pkg::OP_KEY, "9");
    offer_item(kpsc_pkg::OP_KEY, "Z");
    offer_item(kpsc_pkg::OP_KEY, 8'hFF);
    offer_item(kpsc_pkg::OP_KEY, "A");
    // First text item: completes the square, then encrypts to "02".
    offer_item(kpsc_pkg::OP_TEXT, "A");
    offer_item(kpsc_pkg::OP_TEXT, "9");
    // Lowercase gives a flagged space; a space gives a plain space.
    offer_item(kpsc_pkg::OP_TEXT, "z");
    offer_item(kpsc_pkg::OP_TEXT, kpsc_pkg::CHAR_SPACE);
    // A key character after completion and an unused operation change nothing.
    offer_item(kpsc_pkg::OP_KEY, "Q");
    offer_item(OpUnused, "B");
    offer_item(kpsc_pkg::OP_TEXT, "Q");
    // Restart drops the key; the next square is plain alphabet order.
    offer_item(kpsc_pkg::OP_RESTART, 8'h00);
    offer_item(kpsc_pkg::OP_TEXT, "0");
    settle();

    // Directed decrypt checks: the corner cells, a space and an arbitrary byte
    // that break a pair, a lone space, and a digit outside the grid.
    write_mode(1'b0);
    offer_item(kpsc_pkg::OP_TEXT, "0");
    offer_item(kpsc_pkg::OP_TEXT, "0");
    offer_item(kpsc_pkg::OP_TEXT, "5");
    offer_item(kpsc_pkg::OP_TEXT, "5");
    offer_item(kpsc_pkg::OP_TEXT, "3");
    offer_item(kpsc_pkg::OP_TEXT, kpsc_pkg::CHAR_SPACE);
    offer_item(kpsc_pkg::OP_TEXT, kpsc_pkg::CHAR_SPACE);
    offer_item(kpsc_pkg::OP_TEXT, "2");
    offer_item(kpsc_pkg::OP_TEXT, 8'hFF);
    offer_item(kpsc_pkg::OP_TEXT, "9");
    // A row digit survives a trip through encrypt mode and pairs up afterwards.
    offer_item(kpsc_pkg::OP_TEXT, "4");
    settle();
    write_mode(1'b1);
    offer_item(kpsc_pkg::OP_TEXT, "B");
    settle();
    write_mode(1'b0);
    offer_item(kpsc_pkg::OP_TEXT, "1");

    // Random phases. Each begins once everything expected has arrived, may pick
    // a new mode and key, and then streams text. One early phase runs against
    // the long result stall so the block fills and holds off its input.
    phase = 0;
    while (items_sent < ItemTarget) begin
      settle();
      steady = ($urandom_range(0, 5) == 0);
      if (phase == 3) begin
        write_mode(1'b1);
        hold_request = 1'b1;
        encrypt_text(40);
      end else begin
        encrypt = 1'($urandom_range(0, 1));
        write_mode(encrypt);
        if ($urandom_range(0, 1) == 1) begin
          load_random_key();
        end
        if (encrypt) begin
          encrypt_text($urandom_range(10, 50));
        end else begin
          decrypt_text($urandom_range(10, 40));
        end
      end
      phase++;
    end

    settle();
    $display("Run covered %0d input items over %0d random phases and %0d mode writes.",
             items_sent, phase, mode_writes);
    $display("Checked %0d results, %0d mismatches, %0d left over, long stall served: %0d.",
             result_count, mismatch_count, pending_count, hold_served);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("** keyed_polybius_square_cipher: PASSED **");
    end else begin
      $display("** keyed_polybius_square_cipher: FAILED **");
    end
    $finish;
  end

endmodule
